### rtl/core/abm_pkg.sv
// Shared types and constants for the allocation bitmap core.
package abm_pkg;

  localparam int OP_W  = 4;
  localparam int IDX_W = 12;
  localparam int CFG_W = 13;

  // Operation codes
  localparam logic [OP_W-1:0] OP_SET         = 4'd0;
  localparam logic [OP_W-1:0] OP_CLEAR       = 4'd1;
  localparam logic [OP_W-1:0] OP_TEST        = 4'd2;
  localparam logic [OP_W-1:0] OP_SET_ALL     = 4'd3;
  localparam logic [OP_W-1:0] OP_CLEAR_ALL   = 4'd4;
  localparam logic [OP_W-1:0] OP_FIRST_SET   = 4'd5;
  localparam logic [OP_W-1:0] OP_FIRST_CLEAR = 4'd6;
  localparam logic [OP_W-1:0] OP_ALL_SET     = 4'd7;
  localparam logic [OP_W-1:0] OP_ALL_CLEAR   = 4'd8;

  // Reciprocal shifts for dividing a bit index or bit count by the word width
  localparam int DIV_SHIFT_IDX = 19;
  localparam int DIV_SHIFT_CFG = 20;

  localparam logic [CFG_W-1:0] BITS_RESET = 13'd4096;

  typedef struct packed {
    logic             flag;
    logic [IDX_W-1:0] found_index;
    logic             bad_index;
  } res_t;

endpackage

### rtl/core/allocation_bitmap_find_first_core.sv
// Top level of the bitmap allocator with find-first-set and find-first-clear.
// The bitmap lives in one RAM of NUM_WORDS words of WORD_BITS bits, read one word per cycle.
// After reset a clearing pass zeroes every RAM word; no request is taken until
// it ends, while configuration writes are taken at any time. Set, clear and test go
// through accept, decode, read-modify-write and response, and skip the read-modify-write
// step when the bit index is out of range and nothing is read.
// Set all, clear all, the two finds and the two all-equal checks walk the words in use,
// one word per cycle through the RAM; a find or check stops at the first word that
// decides it. Unused opcodes and an empty bitmap go from decode straight to the
// response. A new request is taken while a result still waits.
module allocation_bitmap_find_first_core #(
  parameter int WORD_BITS = 64,
  parameter int NUM_WORDS = 64
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [abm_pkg::CFG_W-1:0]  cfg_bits_in_use,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [abm_pkg::OP_W-1:0]   in_opcode,
  input  logic [abm_pkg::IDX_W-1:0]  in_bit_index,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       out_flag,
  output logic [abm_pkg::IDX_W-1:0]  out_found_index,
  output logic                       out_bad_index
);
  import abm_pkg::*;

  localparam int AW = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int CW = $clog2(NUM_WORDS + 1);
  localparam int BW = $clog2(WORD_BITS);

  // Reciprocals for division by the word width
  localparam int RI   = (2**DIV_SHIFT_IDX + WORD_BITS - 1) / WORD_BITS;
  localparam int RI_W = $clog2(RI + 1);
  localparam int PI_W = IDX_W + RI_W;
  localparam int QI_W = PI_W - DIV_SHIFT_IDX;
  localparam int RC   = (2**DIV_SHIFT_CFG + WORD_BITS - 1) / WORD_BITS;
  localparam int RC_W = $clog2(RC + 1);
  localparam int PC_W = CFG_W + RC_W;
  localparam int QC_W = PC_W - DIV_SHIFT_CFG;

  localparam int RESET_WORDS_INT = (int'(BITS_RESET) / WORD_BITS > NUM_WORDS) ?
                                   NUM_WORDS : int'(BITS_RESET) / WORD_BITS;
  localparam logic [CW-1:0] RESET_WORDS = CW'(RESET_WORDS_INT);

  // State codes
  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_DEC   = 3'd2;
  localparam logic [2:0] ST_RMW   = 3'd3;
  localparam logic [2:0] ST_FILL  = 3'd4;
  localparam logic [2:0] ST_SCAN  = 3'd5;
  localparam logic [2:0] ST_RESP  = 3'd6;

  // Lowest set bit of a word
  function automatic logic [BW-1:0] lowest_one(input logic [WORD_BITS-1:0] v);
    logic [BW-1:0] b;
    b = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (v[i]) begin
        b = BW'(i);
      end
    end
    return b;
  endfunction

  logic [2:0]        state_r, state_nxt;
  logic [CFG_W-1:0]  bits_r;
  logic [CW-1:0]     words_r, words_nxt;
  logic [OP_W-1:0]   op_r, op_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [PI_W-1:0]   prod_r, prod_nxt;
  logic [AW-1:0]     addr_r, addr_nxt;
  logic [BW-1:0]     bitsel_r, bitsel_nxt;
  logic [AW-1:0]     cnt_r, cnt_nxt;
  res_t              res_r, res_nxt;
  res_t              out_r, out_nxt;
  logic              out_valid_r, out_valid_nxt;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [WORD_BITS-1:0] ram_rdata;

  logic [PC_W-1:0]   cfg_prod;
  logic [QC_W-1:0]   cfg_quot;
  logic [QI_W-1:0]   word_q;
  logic [IDX_W-1:0]  word_base;
  logic [IDX_W-1:0]  bit_rem;
  logic              in_range;
  logic [WORD_BITS-1:0] bit_mask;
  logic [WORD_BITS-1:0] probe;
  logic              hit;
  logic              is_find;
  logic              last_word;
  logic [IDX_W-1:0]  found_pos;

  abm_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (NUM_WORDS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Words in use: bits_in_use divided by the word width, saturated at the depth
  assign cfg_prod = PC_W'(bits_r) * PC_W'(RC);
  assign cfg_quot = cfg_prod[PC_W-1:DIV_SHIFT_CFG];
  always_comb begin
    if (int'(cfg_quot) > NUM_WORDS) begin
      words_nxt = CW'(NUM_WORDS);
    end else begin
      words_nxt = CW'(cfg_quot);
    end
  end

  // Split the request index into word and bit
  assign word_q    = prod_r[PI_W-1:DIV_SHIFT_IDX];
  assign word_base = IDX_W'(word_q) * IDX_W'(WORD_BITS);
  assign bit_rem   = idx_r - word_base;
  assign in_range  = IDX_W'(word_q) < IDX_W'(words_r);

  // Word read and scan helpers
  assign bit_mask  = WORD_BITS'(1) << bitsel_r;
  assign probe     = (op_r == OP_FIRST_SET || op_r == OP_ALL_CLEAR) ? ram_rdata : ~ram_rdata;
  assign hit       = |probe;
  assign is_find   = (op_r == OP_FIRST_SET) || (op_r == OP_FIRST_CLEAR);
  assign last_word = CW'(cnt_r) == (words_r - CW'(1));
  assign found_pos = IDX_W'(cnt_r) * IDX_W'(WORD_BITS) + IDX_W'(lowest_one(probe));

  assign cfg_ready = 1'b1;

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    idx_nxt       = idx_r;
    prod_nxt      = prod_r;
    addr_nxt      = addr_r;
    bitsel_nxt    = bitsel_r;
    cnt_nxt       = cnt_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    in_ready      = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = cnt_r;
    ram_wdata     = '0;
    ram_raddr     = cnt_r;

    case (state_r)
      ST_CLEAR: begin
        ram_we = 1'b1;
        if (cnt_r == AW'(NUM_WORDS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = ST_IDLE;
        end else begin
          cnt_nxt = cnt_r + AW'(1);
        end
      end

      ST_IDLE: begin
        in_ready = !cfg_valid;
        if (in_valid && !cfg_valid) begin
          op_nxt    = in_opcode;
          idx_nxt   = in_bit_index;
          prod_nxt  = PI_W'(in_bit_index) * PI_W'(RI);
          state_nxt = ST_DEC;
        end
      end

      ST_DEC: begin
        res_nxt    = '0;
        addr_nxt   = AW'(word_q);
        bitsel_nxt = bit_rem[BW-1:0];
        cnt_nxt    = '0;
        ram_raddr  = '0;
        case (op_r)
          OP_SET, OP_CLEAR, OP_TEST: begin
            if (!in_range) begin
              res_nxt.bad_index = 1'b1;
              state_nxt         = ST_RESP;
            end else begin
              ram_raddr = AW'(word_q);
              state_nxt = ST_RMW;
            end
          end
          OP_SET_ALL, OP_CLEAR_ALL: begin
            state_nxt = (words_r == '0) ? ST_RESP : ST_FILL;
          end
          OP_FIRST_SET, OP_FIRST_CLEAR, OP_ALL_SET, OP_ALL_CLEAR: begin
            if (words_r == '0) begin
              res_nxt.flag = (op_r == OP_ALL_SET) || (op_r == OP_ALL_CLEAR);
              state_nxt    = ST_RESP;
            end else begin
              state_nxt = ST_SCAN;
            end
          end
          default: begin
            state_nxt = ST_RESP;
          end
        endcase
      end

      ST_RMW: begin
        ram_waddr = addr_r;
        case (op_r)
          OP_SET: begin
            ram_we    = 1'b1;
            ram_wdata = ram_rdata | bit_mask;
          end
          OP_CLEAR: begin
            ram_we    = 1'b1;
            ram_wdata = ram_rdata & ~bit_mask;
          end
          default: begin
            res_nxt.flag = ram_rdata[bitsel_r];
          end
        endcase
        state_nxt = ST_RESP;
      end

      ST_FILL: begin
        ram_we    = 1'b1;
        ram_wdata = (op_r == OP_SET_ALL) ? '1 : '0;
        if (last_word) begin
          state_nxt = ST_RESP;
        end else begin
          cnt_nxt = cnt_r + AW'(1);
        end
      end

      ST_SCAN: begin
        // read data belongs to cnt_r; prefetch the next word
        ram_raddr = cnt_r + AW'(1);
        if (hit) begin
          res_nxt.flag        = is_find;
          res_nxt.found_index = is_find ? found_pos : '0;
          state_nxt           = ST_RESP;
        end else if (last_word) begin
          res_nxt.flag = !is_find;
          state_nxt    = ST_RESP;
        end else begin
          cnt_nxt = cnt_r + AW'(1);
        end
      end

      ST_RESP: begin
        if (!out_valid_r || out_ready) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      bits_r      <= BITS_RESET;
      words_r     <= RESET_WORDS;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      words_r     <= words_nxt;
      if (cfg_valid && cfg_ready) begin
        bits_r <= cfg_bits_in_use;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    idx_r    <= idx_nxt;
    prod_r   <= prod_nxt;
    addr_r   <= addr_nxt;
    bitsel_r <= bitsel_nxt;
    res_r    <= res_nxt;
    out_r    <= out_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_flag        = out_r.flag;
  assign out_found_index = out_r.found_index;
  assign out_bad_index   = out_r.bad_index;

endmodule

### rtl/core/abm_ram.sv
// Generic simple dual-port RAM with registered read data.
module abm_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                                           clk,
  input  logic                                           we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   waddr,
  input  logic [WIDTH-1:0]                               wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   raddr,
  output logic [WIDTH-1:0]                               rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### verif/tb_top.sv
// Self-checking testbench for the bitmap allocator core: predicts each result and compares it.
module tb_top;

  import abm_pkg::*;

  localparam int WORD_BITS   = 64;
  localparam int NUM_WORDS   = 64;
  localparam int QUIET_LIMIT = 3000;
  localparam int DRAIN_TAIL  = 100;
  localparam int MAX_REPORTS = 10;
  localparam int IDLE_PCT    = 37;

  // Opcodes the block does not decode
  localparam logic [OP_W-1:0] OP_UNUSED_LO = 4'd9;
  localparam logic [OP_W-1:0] OP_UNUSED_HI = 4'd15;

  localparam logic [CFG_W-1:0] BITS_NONE      = 13'd0;
  localparam logic [CFG_W-1:0] BITS_ONE_WORD  = 13'd64;
  localparam logic [CFG_W-1:0] BITS_PARTIAL   = 13'd100;
  localparam logic [CFG_W-1:0] BITS_SATURATED = 13'd8191;

  logic             clk;
  logic             rst_n           = 1'b0;
  logic             cfg_valid       = 1'b0;
  logic             cfg_ready;
  logic [CFG_W-1:0] cfg_bits_in_use = '0;
  logic             in_valid        = 1'b0;
  logic             in_ready;
  logic [OP_W-1:0]  in_opcode       = '0;
  logic [IDX_W-1:0] in_bit_index    = '0;
  logic             out_valid;
  logic             out_ready       = 1'b0;
  logic             out_flag;
  logic [IDX_W-1:0] out_found_index;
  logic             out_bad_index;

  // Mirror of the block's bitmap and its bits-in-use register
  logic [WORD_BITS-1:0] bitmap_mirror [NUM_WORDS];
  logic [CFG_W-1:0]     bits_in_use_mirror = BITS_RESET;

  res_t        pending_results [$];
  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles   = 0;
  bit          gaps_on        = 1'b1;

  allocation_bitmap_find_first_core #(
    .WORD_BITS(WORD_BITS),
    .NUM_WORDS(NUM_WORDS)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_bits_in_use(cfg_bits_in_use),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_opcode      (in_opcode),
    .in_bit_index   (in_bit_index),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_flag       (out_flag),
    .out_found_index(out_found_index),
    .out_bad_index  (out_bad_index)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Number of words that take part in scans and bounds checks
  function automatic int unsigned live_words();
    int unsigned n;
    n = bits_in_use_mirror / WORD_BITS;
    if (n > NUM_WORDS) n = NUM_WORDS;
    return n;
  endfunction

  // Apply one request to the mirror and return the result it must produce
  function automatic res_t predict_bitmap_op(logic [OP_W-1:0] op, logic [IDX_W-1:0] idx);
    res_t                 res;
    int unsigned          n;
    int unsigned          word_sel;
    int unsigned          bit_pos;
    logic [WORD_BITS-1:0] scan;
    bit                   done;
    res      = '0;
    n        = live_words();
    word_sel = idx / WORD_BITS;
    bit_pos  = idx % WORD_BITS;
    done     = 1'b0;
    case (op)
      OP_SET, OP_CLEAR, OP_TEST: begin
        if (word_sel >= n) begin
          res.bad_index = 1'b1;
        end else if (op == OP_SET) begin
          bitmap_mirror[word_sel][bit_pos] = 1'b1;
        end else if (op == OP_CLEAR) begin
          bitmap_mirror[word_sel][bit_pos] = 1'b0;
        end else begin
          res.flag = bitmap_mirror[word_sel][bit_pos];
        end
      end
      OP_SET_ALL, OP_CLEAR_ALL: begin
        for (int i = 0; i < n; i++)
          bitmap_mirror[i] = (op == OP_SET_ALL) ? '1 : '0;
      end
      OP_FIRST_SET, OP_FIRST_CLEAR: begin
        for (int i = 0; i < n && !done; i++) begin
          scan = (op == OP_FIRST_SET) ? bitmap_mirror[i] : ~bitmap_mirror[i];
          for (int b = 0; b < WORD_BITS && !done; b++) begin
            if (scan[b]) begin
              done            = 1'b1;
              res.flag        = 1'b1;
              res.found_index = IDX_W'(i * WORD_BITS + b);
            end
          end
        end
      end
      OP_ALL_SET, OP_ALL_CLEAR: begin
        res.flag = 1'b1;
        for (int i = 0; i < n; i++)
          if (bitmap_mirror[i] != ((op == OP_ALL_SET) ? '1 : '0)) res.flag = 1'b0;
      end
      default: res = '0;
    endcase
    return res;
  endfunction

  task automatic note_mismatch(input string what, input int unsigned exp_v,
                               input int unsigned got_v);
    if (mismatch_count < MAX_REPORTS)
      $display("mismatch on %s: expected %0d, got %0d", what, exp_v, got_v);
    mismatch_count++;
  endtask

  // Check each result against the oldest prediction, drive out_ready, track quiet cycles
  always @(posedge clk) begin
    res_t exp_res;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        note_mismatch("unexpected result, flag", 0, 32'(out_flag));
      end else begin
        exp_res = pending_results.pop_front();
        if (out_flag !== exp_res.flag)
          note_mismatch("flag", 32'(exp_res.flag), 32'(out_flag));
        if (out_found_index !== exp_res.found_index)
          note_mismatch("found_index", 32'(exp_res.found_index), 32'(out_found_index));
        if (out_bad_index !== exp_res.bad_index)
          note_mismatch("bad_index", 32'(exp_res.bad_index), 32'(out_bad_index));
      end
    end
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    out_ready <= !gaps_on || ($urandom_range(99) >= IDLE_PCT);
  end

  // Stop a hung run
  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("FAIL allocation_bitmap_find_first_core");
    $finish;
  end

  // Drop valid and hold until every predicted result has come back
  task automatic wait_results_drained();
    if (in_valid) in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Send one request, idling first at random, and record its prediction
  task automatic send_request(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx);
    if (gaps_on && $urandom_range(99) < IDLE_PCT) begin
      if (in_valid) in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < IDLE_PCT);
    end
    in_valid     <= 1'b1;
    in_opcode    <= op;
    in_bit_index <= idx;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(predict_bitmap_op(op, idx));
  endtask

  // Write bits_in_use once the block is idle
  task automatic write_bits_in_use(input logic [CFG_W-1:0] value);
    wait_results_drained();
    cfg_valid       <= 1'b1;
    cfg_bits_in_use <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid          <= 1'b0;
    bits_in_use_mirror  = value;
  endtask

  // Pick a weighted random request, mostly inside the words in use
  task automatic send_random_request();
    logic [OP_W-1:0]  op;
    logic [IDX_W-1:0] idx;
    int unsigned      n;
    int unsigned      pick;
    n    = live_words();
    pick = $urandom_range(99);
    if      (pick < 25) op = OP_SET;
    else if (pick < 45) op = OP_CLEAR;
    else if (pick < 58) op = OP_TEST;
    else if (pick < 62) op = OP_SET_ALL;
    else if (pick < 66) op = OP_CLEAR_ALL;
    else if (pick < 76) op = OP_FIRST_SET;
    else if (pick < 86) op = OP_FIRST_CLEAR;
    else if (pick < 91) op = OP_ALL_SET;
    else if (pick < 96) op = OP_ALL_CLEAR;
    else                op = OP_W'($urandom_range(OP_UNUSED_HI, OP_UNUSED_LO));
    if (n != 0 && $urandom_range(99) < 85)
      idx = IDX_W'($urandom_range(n * WORD_BITS - 1, 0));
    else
      idx = IDX_W'($urandom_range(4095, 0));
    send_request(op, idx);
  endtask

  // Walk every operation at the reset size, including the extreme bit numbers
  task automatic test_directed_ops();
    send_request(OP_SET, 12'd0);
    send_request(OP_SET, 12'd4095);
    send_request(OP_TEST, 12'd0);
    send_request(OP_TEST, 12'd1);
    send_request(OP_TEST, 12'd4095);
    send_request(OP_FIRST_SET, 12'd0);
    send_request(OP_CLEAR, 12'd0);
    send_request(OP_FIRST_SET, 12'd0);
    send_request(OP_FIRST_CLEAR, 12'd4095);
    send_request(OP_SET_ALL, 12'd0);
    send_request(OP_ALL_SET, 12'd0);
    send_request(OP_FIRST_CLEAR, 12'd0);
    send_request(OP_CLEAR_ALL, 12'd0);
    send_request(OP_ALL_CLEAR, 12'd0);
    send_request(OP_FIRST_SET, 12'd0);
    send_request(OP_UNUSED_LO, 12'd0);
    send_request(OP_UNUSED_HI, 12'd4095);
  endtask

  // Empty bitmap, partial last word, untouched upper words, saturated size
  task automatic test_config_corners();
    write_bits_in_use(BITS_NONE);
    send_request(OP_SET, 12'd5);
    send_request(OP_FIRST_CLEAR, 12'd0);
    send_request(OP_ALL_SET, 12'd0);
    write_bits_in_use(BITS_PARTIAL);
    send_request(OP_TEST, 12'd64);
    send_request(OP_SET_ALL, 12'd0);
    send_request(OP_ALL_SET, 12'd0);
    write_bits_in_use(BITS_SATURATED);
    send_request(OP_FIRST_CLEAR, 12'd0);
    send_request(OP_TEST, 12'd4095);
    write_bits_in_use(BITS_ONE_WORD);
    send_request(OP_CLEAR, 12'd63);
    send_request(OP_FIRST_CLEAR, 12'd0);
  endtask

  // Random requests across a range of bitmap sizes
  task automatic test_random_sweep();
    logic [CFG_W-1:0] sizes [8];
    sizes[0] = BITS_RESET;
    sizes[1] = BITS_ONE_WORD;
    sizes[2] = CFG_W'($urandom_range(8, 2) * WORD_BITS);
    sizes[3] = BITS_NONE;
    sizes[4] = BITS_SATURATED;
    sizes[5] = CFG_W'($urandom_range(8191, 0));
    sizes[6] = BITS_PARTIAL;
    sizes[7] = CFG_W'($urandom_range(64, 1) * WORD_BITS);
    foreach (sizes[s]) begin
      write_bits_in_use(sizes[s]);
      repeat (50) send_random_request();
    end
  endtask

  // Full rate on both sides with long scans
  task automatic test_back_to_back();
    write_bits_in_use(BITS_RESET);
    gaps_on = 1'b0;
    repeat (200) send_random_request();
    gaps_on = 1'b1;
  endtask

  // Hold the sender until the block has returned everything
  task automatic test_drain_pauses();
    write_bits_in_use(CFG_W'($urandom_range(16, 1) * WORD_BITS));
    repeat (4) begin
      repeat (15) send_random_request();
      wait_results_drained();
    end
  endtask

  initial begin
    for (int i = 0; i < NUM_WORDS; i++) bitmap_mirror[i] = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_ops();
    test_config_corners();
    test_random_sweep();
    test_back_to_back();
    test_drain_pauses();
    wait_results_drained();
    repeat (DRAIN_TAIL) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("PASS allocation_bitmap_find_first_core");
    end else begin
      $display("FAIL allocation_bitmap_find_first_core");
    end
    $finish;
  end

endmodule
